### rtl/datetime_text_parser_assert.svh
// Assertion macros shared by the date-time parser modules.
`ifndef DATETIME_TEXT_PARSER_ASSERT_SVH
`define DATETIME_TEXT_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define DTP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dtp_pkg.sv
// Types and constants shared by the date-time parser modules.
package dtp_pkg;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [1:0] FORM_FULL = 2'd0;
  localparam logic [1:0] FORM_DATE = 2'd1;
  localparam logic [1:0] FORM_TIME = 2'd2;

  localparam logic [13:0] EPOCH_YEAR  = 14'd1970;
  localparam logic [4:0]  MONTH_MAX   = 5'd12;
  localparam logic [5:0]  DAY_MAX     = 6'd31;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [5:0]  SEXAGES_MAX = 6'd59;

  typedef struct packed {
    logic       is_digit;
    logic       is_space;
    logic       is_dash;
    logic       is_colon;
    logic [3:0] digit;
    logic       last;
  } char_class_t;

endpackage

### rtl/datetime_text_parser.sv
// Top level of the streaming date-time text parser.
// Characters arrive on the input channel (in_valid / in_ready) with last_char
// marking the final character of a string; each request carries one byte.
// One result request per string leaves on the output channel (out_valid /
// out_ready) carrying parse_ok, form_kind and the date and time fields.
// A failed string gives parse_ok low and every other field zero.
// Throughput is one character per cycle while results are taken: the front
// end classifies a byte and queues it, and the back end steps the parse
// state machine once per cycle. The back end takes the last character of a
// string from the head of the queue and loads the result register, raising
// out_valid, at the same edge that pops that character from the queue.
// When the receiver stalls, the result register holds, the back end keeps
// consuming characters until the next last character reaches the head of the
// queue, and in_ready drops once one more character sits behind it.
// Reset empties the queue, returns the parser to its start state, drops
// out_valid and clears strict_mode. Write strict_mode through cfg_we and
// cfg_wdata only while no string is in flight.
module datetime_text_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        parse_ok,
  output logic [1:0]  form_kind,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);
  import dtp_pkg::*;

  logic        strict_mode;
  logic        head_valid;
  char_class_t head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (cfg_we) begin
      strict_mode <= cfg_wdata;
    end
  end

  dtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_byte  (char_byte),
    .last_char  (last_char),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  dtp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .strict_mode (strict_mode),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .parse_ok    (parse_ok),
    .form_kind   (form_kind),
    .year_out    (year_out),
    .month_out   (month_out),
    .day_out     (day_out),
    .hour_out    (hour_out),
    .minute_out  (minute_out),
    .second_out  (second_out)
  );

endmodule

### rtl/dtp_front.sv
// Front end: classifies each character and holds it in a two-entry queue.
`include "datetime_text_parser_assert.svh"

module dtp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_byte,
  input  logic                last_char,
  output logic                head_valid,
  output dtp_pkg::char_class_t head,
  input  logic                pop
);
  import dtp_pkg::*;

  char_class_t entry [2];
  char_class_t cls;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  always_comb begin
    cls.is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
    cls.is_space = (char_byte == CHAR_SPACE) ||
                   ((char_byte >= CHAR_TAB) && (char_byte <= CHAR_CR));
    cls.is_dash  = (char_byte == CHAR_DASH);
    cls.is_colon = (char_byte == CHAR_COLON);
    cls.digit    = char_byte[3:0];
    cls.last     = last_char;
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `DTP_ASSERT_IMPL(q_count_max, 1'b1, count <= 2'd2, "queue count above depth")
  `DTP_ASSERT_IMPL(q_pop_nonempty, pop, count != 2'd0, "pop from empty queue")
  `DTP_ASSERT_NEXT(q_count_track, push && !pop, count == $past(count) + 2'd1, "count missed a push")

endmodule

### rtl/dtp_back.sv
// Back end: date-time parse state machine and the result register.
`include "datetime_text_parser_assert.svh"

module dtp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 strict_mode,
  input  logic                 head_valid,
  input  dtp_pkg::char_class_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 parse_ok,
  output logic [1:0]           form_kind,
  output logic [13:0]          year_out,
  output logic [3:0]           month_out,
  output logic [4:0]           day_out,
  output logic [4:0]           hour_out,
  output logic [5:0]           minute_out,
  output logic [5:0]           second_out
);
  import dtp_pkg::*;

  typedef enum logic [3:0] {
    PH_LEAD, PH_FIRST, PH_MONTH, PH_DAY, PH_MID,
    PH_HOUR, PH_MINUTE, PH_SECOND, PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic [5:0] v;
    logic [2:0] cnt;
    logic       fail;
  } digit_res_t;

  localparam logic [5:0] MONTH_LEAD_MAX = 6'd1;
  localparam logic [5:0] DAY_LEAD_MAX   = 6'd3;
  localparam logic [5:0] HOUR_LEAD_MAX  = 6'd2;
  localparam logic [5:0] SEXAG_LEAD_MAX = 6'd5;
  localparam logic [13:0] HOUR_FIRST_LIM = 14'd30;

  function automatic digit_res_t take_digit(input logic [5:0] v, input logic [2:0] cnt,
                                            input logic [3:0] d, input logic [5:0] lim);
    digit_res_t r;
    r.v    = v;
    r.cnt  = cnt;
    r.fail = 1'b0;
    if (cnt == 3'd0) begin
      r.v   = {2'b00, d};
      r.cnt = 3'd1;
    end else if ((cnt == 3'd1) && (v <= lim)) begin
      r.v   = 6'(v * 6'd10) + {2'b00, d};
      r.cnt = 3'd2;
    end else begin
      r.fail = 1'b1;
    end
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [13:0] first_group, first_group_next;
  logic [4:0]  month_value, month_value_next;
  logic [5:0]  day_value, day_value_next;
  logic [4:0]  hour_value, hour_value_next;
  logic [5:0]  minute_value, minute_value_next;
  logic [5:0]  second_value, second_value_next;
  logic        failed, failed_next;
  logic        time_only, time_only_next;
  digit_res_t  dr;

  logic        date_end, time_end, date_ok, hour_ok;
  logic        res_ok;
  logic [1:0]  res_form;
  logic        res_date, res_time;
  logic        out_zero, out_in_range, state_clear;

  assign pop = head_valid && (!head.last || !out_valid || out_ready);

  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    first_group_next  = first_group;
    month_value_next  = month_value;
    day_value_next    = day_value;
    hour_value_next   = hour_value;
    minute_value_next = minute_value;
    second_value_next = second_value;
    failed_next       = failed;
    time_only_next    = time_only;
    dr                = '0;
    if (!failed) begin
      unique case (phase)
        PH_LEAD: begin
          if (head.is_space) begin
          end else if (head.is_digit) begin
            phase_next       = PH_FIRST;
            digit_count_next = 3'd1;
            first_group_next = {10'd0, head.digit};
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_FIRST: begin
          if (head.is_digit) begin
            if (digit_count >= 3'd4) begin
              failed_next = 1'b1;
            end else begin
              first_group_next = 14'(first_group * 14'd10) + {10'd0, head.digit};
              digit_count_next = digit_count + 3'd1;
            end
          end else if (head.is_dash && (digit_count == 3'd4)) begin
            phase_next       = PH_MONTH;
            digit_count_next = 3'd0;
          end else if (head.is_colon && ((digit_count == 3'd1) ||
                       ((digit_count == 3'd2) && (first_group < HOUR_FIRST_LIM)))) begin
            hour_value_next  = first_group[4:0];
            time_only_next   = 1'b1;
            phase_next       = PH_MINUTE;
            digit_count_next = 3'd0;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_MONTH: begin
          if (head.is_digit) begin
            dr = take_digit({1'b0, month_value}, digit_count, head.digit, MONTH_LEAD_MAX);
            month_value_next = dr.v[4:0];
            digit_count_next = dr.cnt;
            failed_next      = dr.fail;
          end else if (head.is_dash && (digit_count != 3'd0)) begin
            phase_next       = PH_DAY;
            digit_count_next = 3'd0;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_DAY: begin
          if (head.is_digit) begin
            dr = take_digit(day_value, digit_count, head.digit, DAY_LEAD_MAX);
            day_value_next   = dr.v;
            digit_count_next = dr.cnt;
            failed_next      = dr.fail;
          end else if (head.is_space && (digit_count != 3'd0)) begin
            phase_next = PH_MID;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_MID: begin
          if (head.is_space) begin
          end else if (head.is_digit) begin
            phase_next       = PH_HOUR;
            digit_count_next = 3'd1;
            hour_value_next  = {1'b0, head.digit};
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_HOUR: begin
          if (head.is_digit) begin
            dr = take_digit({1'b0, hour_value}, digit_count, head.digit, HOUR_LEAD_MAX);
            hour_value_next  = dr.v[4:0];
            digit_count_next = dr.cnt;
            failed_next      = dr.fail;
          end else if (head.is_colon && (digit_count != 3'd0)) begin
            phase_next       = PH_MINUTE;
            digit_count_next = 3'd0;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_MINUTE: begin
          if (head.is_digit) begin
            dr = take_digit(minute_value, digit_count, head.digit, SEXAG_LEAD_MAX);
            minute_value_next = dr.v;
            digit_count_next  = dr.cnt;
            failed_next       = dr.fail;
          end else if (head.is_colon && (digit_count != 3'd0)) begin
            phase_next       = PH_SECOND;
            digit_count_next = 3'd0;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_SECOND: begin
          if (head.is_digit) begin
            dr = take_digit(second_value, digit_count, head.digit, SEXAG_LEAD_MAX);
            second_value_next = dr.v;
            digit_count_next  = dr.cnt;
            failed_next       = dr.fail;
          end else if (head.is_space && (digit_count != 3'd0)) begin
            phase_next = PH_TRAIL;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!head.is_space) begin
            failed_next = 1'b1;
          end
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    date_end = ((phase_next == PH_DAY) && (digit_count_next != 3'd0)) ||
               (phase_next == PH_MID);
    time_end = ((phase_next == PH_SECOND) && (digit_count_next != 3'd0)) ||
               (phase_next == PH_TRAIL);
    date_ok  = (month_value_next != 5'd0) && (month_value_next <= MONTH_MAX) &&
               (day_value_next != 6'd0) && (day_value_next <= DAY_MAX);
    hour_ok  = (hour_value_next <= HOUR_MAX);
    res_ok   = 1'b0;
    res_form = FORM_FULL;
    res_date = 1'b0;
    res_time = 1'b0;
    if (!failed_next) begin
      priority if (date_end && !strict_mode && date_ok) begin
        res_ok   = 1'b1;
        res_form = FORM_DATE;
        res_date = 1'b1;
      end else if (time_end && time_only_next) begin
        if (!strict_mode && hour_ok) begin
          res_ok   = 1'b1;
          res_form = FORM_TIME;
          res_time = 1'b1;
        end
      end else if (time_end && date_ok && hour_ok) begin
        res_ok   = 1'b1;
        res_form = FORM_FULL;
        res_date = 1'b1;
        res_time = 1'b1;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      digit_count  <= 3'd0;
      first_group  <= '0;
      month_value  <= '0;
      day_value    <= '0;
      hour_value   <= '0;
      minute_value <= '0;
      second_value <= '0;
      failed       <= 1'b0;
      time_only    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop && head.last) begin
        phase        <= PH_LEAD;
        digit_count  <= 3'd0;
        first_group  <= '0;
        month_value  <= '0;
        day_value    <= '0;
        hour_value   <= '0;
        minute_value <= '0;
        second_value <= '0;
        failed       <= 1'b0;
        time_only    <= 1'b0;
        out_valid    <= 1'b1;
        parse_ok     <= res_ok;
        form_kind    <= res_form;
        if (res_date) begin
          year_out  <= first_group_next;
          month_out <= month_value_next[3:0];
          day_out   <= day_value_next[4:0];
        end else if (res_time) begin
          year_out  <= EPOCH_YEAR;
          month_out <= 4'd1;
          day_out   <= 5'd1;
        end else begin
          year_out  <= '0;
          month_out <= '0;
          day_out   <= '0;
        end
        if (res_time) begin
          hour_out   <= hour_value_next;
          minute_out <= minute_value_next;
          second_out <= second_value_next;
        end else begin
          hour_out   <= '0;
          minute_out <= '0;
          second_out <= '0;
        end
      end else begin
        if (pop) begin
          phase        <= phase_next;
          digit_count  <= digit_count_next;
          first_group  <= first_group_next;
          month_value  <= month_value_next;
          day_value    <= day_value_next;
          hour_value   <= hour_value_next;
          minute_value <= minute_value_next;
          second_value <= second_value_next;
          failed       <= failed_next;
          time_only    <= time_only_next;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign out_zero = (form_kind == FORM_FULL) && (year_out == 14'd0) && (month_out == 4'd0) &&
                    (day_out == 5'd0) && (hour_out == 5'd0) && (minute_out == 6'd0) &&
                    (second_out == 6'd0);
  assign out_in_range = (month_out != 4'd0) && ({1'b0, month_out} <= MONTH_MAX) &&
                        (day_out != 5'd0) && (hour_out <= HOUR_MAX) &&
                        (minute_out <= SEXAGES_MAX) && (second_out <= SEXAGES_MAX);
  assign state_clear = (phase == PH_LEAD) && !failed && !time_only && (digit_count == 3'd0);

  `DTP_ASSERT_IMPL(fail_all_zero, out_valid && !parse_ok, out_zero, "failed result not all zero")
  `DTP_ASSERT_IMPL(ok_in_range, out_valid && parse_ok, out_in_range, "accepted result out of range")
  `DTP_ASSERT_NEXT(clear_after_last, pop && head.last, state_clear, "state not cleared after last")

endmodule
